>>> hdl/msq_pkg.sv
// Shared types, constants and song tables for the melody sequencer.
// Used by msq_ctrl, msq_datapath and the top level; depends on nothing.
package msq_pkg;

  localparam int NOTE_DEPTH        = 128;
  localparam int FIRST_SONG_NOTES  = 58;
  localparam int SECOND_SONG_NOTES = 74;
  localparam int POS_W             = $clog2(NOTE_DEPTH);
  localparam int CNT_W             = $clog2(NOTE_DEPTH + 1);

  localparam int TONE_W  = 14;
  localparam int LEN_W   = 9;
  localparam int DUR_W   = 10;
  localparam int TEMPO_W = 8;
  localparam int GAP_W   = 4;
  localparam int HOLD_W  = 8;
  localparam int DIV_STEPS = DUR_W;
  localparam int STEP_W  = $clog2(DIV_STEPS + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_GAP_TICKS   = 2'd0;
  localparam logic [1:0] CFG_HOLD_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_FIRST_TEMPO = 2'd2;
  localparam logic [1:0] CFG_SECOND_TEMPO = 2'd3;

  // Status bit positions
  localparam int ST_PAUSED   = 0;
  localparam int ST_FRESH    = 1;
  localparam int ST_FINISHED = 2;
  localparam int ST_SOUND    = 3;

  localparam logic [3:0] STATUS_RESET = 4'b0011;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 8'd8;
  localparam logic [GAP_W-1:0]   GAP_RESET    = 4'd5;
  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 8'd201;
  localparam logic [TEMPO_W-1:0] SECOND_RESET = 8'd4;

  typedef struct packed {
    logic [TONE_W-1:0] tone;
    logic [LEN_W-1:0]  len;
  } note_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_COMMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } dp_status_t;

  localparam note_t SONG_A [FIRST_SONG_NOTES] = '{
    {14'd955,9'd200},{14'd955,9'd200},{14'd1012,9'd150},{14'd1136,9'd50},
    {14'd1275,9'd300},{14'd1431,9'd100},{14'd1516,9'd200},{14'd1702,9'd200},
    {14'd1910,9'd300},{14'd1275,9'd100},{14'd1136,9'd300},{14'd1136,9'd100},
    {14'd1012,9'd300},{14'd1012,9'd100},{14'd955,9'd300},{14'd955,9'd100},
    {14'd955,9'd100},{14'd1012,9'd100},{14'd1136,9'd100},{14'd1275,9'd100},
    {14'd1275,9'd150},{14'd1431,9'd50},{14'd1516,9'd100},{14'd955,9'd100},
    {14'd955,9'd100},{14'd1012,9'd100},{14'd1136,9'd100},{14'd1275,9'd100},
    {14'd1275,9'd150},{14'd1431,9'd50},{14'd1516,9'd100},{14'd1516,9'd100},
    {14'd1516,9'd100},{14'd1516,9'd100},{14'd1516,9'd100},{14'd1516,9'd50},
    {14'd1431,9'd50},{14'd1275,9'd300},{14'd1431,9'd50},{14'd1516,9'd50},
    {14'd1702,9'd100},{14'd1702,9'd100},{14'd1702,9'd100},{14'd1702,9'd50},
    {14'd1516,9'd50},{14'd1431,9'd300},{14'd1516,9'd50},{14'd1702,9'd50},
    {14'd1516,9'd100},{14'd955,9'd200},{14'd1136,9'd100},{14'd1275,9'd150},
    {14'd1431,9'd50},{14'd1516,9'd100},{14'd1431,9'd100},{14'd1516,9'd200},
    {14'd1702,9'd200},{14'd1910,9'd400}
  };

  localparam note_t SONG_B [SECOND_SONG_NOTES] = '{
    {14'd637,9'd100},{14'd637,9'd100},{14'd478,9'd100},{14'd637,9'd100},
    {14'd955,9'd50},{14'd955,9'd50},{14'd637,9'd100},{14'd478,9'd100},
    {14'd637,9'd100},{14'd20,9'd100},{14'd637,9'd100},{14'd478,9'd100},
    {14'd637,9'd100},{14'd478,9'd100},{14'd379,9'd150},{14'd425,9'd50},
    {14'd478,9'd50},{14'd506,9'd50},{14'd568,9'd50},{14'd602,9'd50},
    {14'd637,9'd100},{14'd478,9'd100},{14'd637,9'd100},{14'd955,9'd50},
    {14'd955,9'd50},{14'd637,9'd100},{14'd478,9'd100},{14'd637,9'd200},
    {14'd478,9'd100},{14'd20,9'd50},{14'd568,9'd50},{14'd637,9'd100},
    {14'd715,9'd100},{14'd758,9'd100},{14'd851,9'd100},{14'd955,9'd100},
    {14'd20,9'd100},{14'd1072,9'd100},{14'd803,9'd100},{14'd1072,9'd100},
    {14'd1606,9'd100},{14'd1072,9'd100},{14'd803,9'd100},{14'd1072,9'd200},
    {14'd1072,9'd100},{14'd803,9'd100},{14'd1072,9'd100},{14'd803,9'd100},
    {14'd637,9'd100},{14'd20,9'd50},{14'd715,9'd50},{14'd803,9'd50},
    {14'd851,9'd50},{14'd955,9'd50},{14'd1012,9'd50},{14'd1072,9'd100},
    {14'd803,9'd100},{14'd1072,9'd100},{14'd1606,9'd100},{14'd1072,9'd100},
    {14'd803,9'd100},{14'd1072,9'd200},{14'd803,9'd100},{14'd20,9'd50},
    {14'd955,9'd50},{14'd1072,9'd100},{14'd1203,9'd100},{14'd1275,9'd100},
    {14'd20,9'd100},{14'd1431,9'd100},{14'd1606,9'd100},{14'd2144,9'd100},
    {14'd6424,9'd100},{14'd0,9'd200}
  };

  // Notes past the end of a song read as zero
  function automatic note_t fetch_note(input logic song, input logic [POS_W-1:0] idx);
    note_t n;
    n = '0;
    if (!song) begin
      if (int'(idx) < FIRST_SONG_NOTES) n = SONG_A[idx[$clog2(FIRST_SONG_NOTES)-1:0]];
    end else begin
      if (int'(idx) < SECOND_SONG_NOTES) n = SONG_B[idx[$clog2(SECOND_SONG_NOTES)-1:0]];
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] song_count(input logic song);
    int n;
    n = song ? SECOND_SONG_NOTES : FIRST_SONG_NOTES;
    if (n > NOTE_DEPTH) n = NOTE_DEPTH;
    return CNT_W'(n);
  endfunction

endpackage

>>> hdl/msq_ctrl.sv
// Controller state machine for the melody sequencer.
// Sequences load, divide, commit and emit; depends on msq_pkg.
module msq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  msq_pkg::dp_status_t status,
  output msq_pkg::ctrl_cmd_t  cmd
);

  msq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      msq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = msq_pkg::S_DIVIDE;
        end
      end
      msq_pkg::S_DIVIDE: begin
        if (status.div_done) begin
          state_next = msq_pkg::S_COMMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      msq_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = msq_pkg::S_EMIT;
      end
      msq_pkg::S_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = msq_pkg::S_IDLE;
        end
      end
      default: state_next = msq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> hdl/msq_datapath.sv
// Datapath of the melody sequencer: config registers, playback state,
// restoring divider for note length and the output register. Uses msq_pkg.
module msq_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  msq_pkg::ctrl_cmd_t         cmd,
  output msq_pkg::dp_status_t        status,
  input  logic [3:0]                 buttons,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [msq_pkg::TONE_W-1:0] tone_half_period,
  output logic                       tone_enable,
  output logic                       red_led,
  output logic                       green_led,
  output logic                       finished_flag
);

  // configuration
  logic [msq_pkg::GAP_W-1:0]   gap_ticks;
  logic [msq_pkg::HOLD_W-1:0]  hold_limit;
  logic [msq_pkg::TEMPO_W-1:0] first_song_tempo;
  logic [msq_pkg::TEMPO_W-1:0] second_song_tempo;

  // playback state
  logic [3:0]                  previous_buttons;
  logic                        start_held;
  logic [msq_pkg::HOLD_W-1:0]  hold_count;
  logic                        song_choice;
  logic [msq_pkg::POS_W-1:0]   note_position;
  logic [msq_pkg::DUR_W-1:0]   duration_left;
  logic [msq_pkg::GAP_W-1:0]   gap_count;
  logic [msq_pkg::TEMPO_W-1:0] tempo_halves;
  logic [3:0]                  status_bits;
  logic                        led_red;
  logic                        led_green;
  logic [3:0]                  btn;

  // divider
  logic [msq_pkg::DUR_W-1:0]   quotient;
  logic [msq_pkg::TEMPO_W-1:0] remainder;
  logic [msq_pkg::TEMPO_W-1:0] divisor;
  logic [msq_pkg::STEP_W-1:0]  steps_left;
  logic [msq_pkg::TEMPO_W:0]   trial;
  logic                        fits;
  msq_pkg::note_t              load_note;

  // next values
  logic [3:0]                  fall, rise;
  logic [3:0]                  previous_buttons_next;
  logic                        start_held_next;
  logic [msq_pkg::HOLD_W-1:0]  hold_count_next;
  logic                        song_choice_next;
  logic [msq_pkg::POS_W-1:0]   note_position_next;
  logic [msq_pkg::DUR_W-1:0]   duration_left_next;
  logic [msq_pkg::GAP_W-1:0]   gap_count_next;
  logic [msq_pkg::TEMPO_W-1:0] tempo_halves_next;
  logic [3:0]                  status_bits_next;
  logic                        led_red_next;
  logic                        led_green_next;
  logic [msq_pkg::POS_W-1:0]   tone_index;
  msq_pkg::note_t              out_note;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks         <= msq_pkg::GAP_RESET;
      hold_limit        <= msq_pkg::HOLD_RESET;
      first_song_tempo  <= msq_pkg::TEMPO_RESET;
      second_song_tempo <= msq_pkg::SECOND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msq_pkg::CFG_GAP_TICKS:    gap_ticks         <= cfg_data[msq_pkg::GAP_W-1:0];
        msq_pkg::CFG_HOLD_LIMIT:   hold_limit        <= cfg_data;
        msq_pkg::CFG_FIRST_TEMPO:  first_song_tempo  <= cfg_data;
        msq_pkg::CFG_SECOND_TEMPO: second_song_tempo <= cfg_data;
        default: ;
      endcase
    end
  end

  // Restoring divider: 2*length / tempo, one quotient bit per step
  assign load_note = msq_pkg::fetch_note(song_choice, note_position);
  assign trial     = {remainder, quotient[msq_pkg::DUR_W-1]};
  assign fits      = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (cmd.load) begin
      steps_left <= msq_pkg::STEP_W'(msq_pkg::DIV_STEPS);
    end else if (cmd.div_step) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      btn       <= buttons;
      quotient  <= {load_note.len, 1'b0};
      remainder <= '0;
      divisor   <= (tempo_halves == '0) ? msq_pkg::TEMPO_W'(1) : tempo_halves;
    end else if (cmd.div_step) begin
      remainder <= fits ? msq_pkg::TEMPO_W'(trial - {1'b0, divisor})
                        : trial[msq_pkg::TEMPO_W-1:0];
      quotient  <= {quotient[msq_pkg::DUR_W-2:0], fits};
    end
  end

  assign status.div_done = (steps_left == '0);
  assign status.out_busy = m_tvalid && !m_tready;

  // One tick of the sequencer, in the order timing, start, slower, faster, select
  always_comb begin
    fall = previous_buttons & ~btn;
    rise = ~previous_buttons & btn;
    start_held_next    = start_held;
    hold_count_next    = hold_count;
    song_choice_next   = song_choice;
    note_position_next = note_position;
    duration_left_next = duration_left;
    gap_count_next     = gap_count;
    tempo_halves_next  = tempo_halves;
    status_bits_next   = status_bits;
    led_red_next       = led_red;
    led_green_next     = led_green;

    if (duration_left == '0) begin
      if (gap_count == '0) status_bits_next[msq_pkg::ST_SOUND] = 1'b0;
      if (gap_count == gap_ticks) begin
        gap_count_next = '0;
        led_green_next = !song_choice;
        led_red_next   = song_choice;
        if ({1'b0, note_position} >= msq_pkg::song_count(song_choice)) begin
          status_bits_next[msq_pkg::ST_SOUND]    = 1'b0;
          status_bits_next[msq_pkg::ST_PAUSED]   = 1'b1;
          status_bits_next[msq_pkg::ST_FRESH]    = 1'b1;
          status_bits_next[msq_pkg::ST_FINISHED] = 1'b1;
        end else begin
          duration_left_next = quotient;
          if (!status_bits_next[msq_pkg::ST_FRESH]) status_bits_next[msq_pkg::ST_SOUND] = 1'b1;
          note_position_next = note_position + 1'b1;
        end
      end else begin
        gap_count_next = gap_count + 1'b1;
      end
    end else if (!status_bits[msq_pkg::ST_PAUSED]) begin
      duration_left_next = duration_left - 1'b1;
    end

    if (fall[0]) begin
      status_bits_next[msq_pkg::ST_FRESH] = 1'b0;
      start_held_next = 1'b1;
      if (hold_count != '1) hold_count_next = hold_count + 1'b1;
      if (!status_bits_next[msq_pkg::ST_PAUSED]) begin
        if (!song_choice) led_green_next = 1'b1;
        else led_red_next = 1'b1;
        if (status_bits_next[msq_pkg::ST_FINISHED]) begin
          status_bits_next[msq_pkg::ST_SOUND] = 1'b0;
        end else begin
          status_bits_next[msq_pkg::ST_SOUND] = !status_bits_next[msq_pkg::ST_SOUND];
        end
        status_bits_next[msq_pkg::ST_PAUSED] = 1'b1;
      end else begin
        status_bits_next[msq_pkg::ST_PAUSED] = 1'b0;
        led_green_next = 1'b0;
        led_red_next   = 1'b0;
      end
    end else if (rise[0]) begin
      start_held_next = 1'b0;
      hold_count_next = '0;
    end else if (start_held) begin
      if (hold_count != '1) hold_count_next = hold_count + 1'b1;
      // long hold: restart the current song
      if (hold_count_next >= hold_limit) begin
        note_position_next = '0;
        hold_count_next    = '0;
        status_bits_next[msq_pkg::ST_FRESH]    = 1'b1;
        status_bits_next[msq_pkg::ST_FINISHED] = 1'b0;
        tempo_halves_next  = song_choice ? second_song_tempo : first_song_tempo;
      end
    end

    if (fall[1] && tempo_halves_next > msq_pkg::TEMPO_W'(1)) begin
      tempo_halves_next = tempo_halves_next - 1'b1;
    end
    if (fall[2] && tempo_halves_next != '1) begin
      tempo_halves_next = tempo_halves_next + 1'b1;
    end
    if (fall[3]) begin
      note_position_next = '0;
      song_choice_next   = !song_choice;
      status_bits_next[msq_pkg::ST_FINISHED] = 1'b0;
      tempo_halves_next  = song_choice_next ? second_song_tempo : first_song_tempo;
    end
    previous_buttons_next = btn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
      start_held       <= 1'b0;
      hold_count       <= '0;
      song_choice      <= 1'b0;
      note_position    <= '0;
      duration_left    <= '0;
      gap_count        <= '0;
      tempo_halves     <= msq_pkg::TEMPO_RESET;
      status_bits      <= msq_pkg::STATUS_RESET;
      led_red          <= 1'b0;
      led_green        <= 1'b0;
    end else if (cmd.commit) begin
      previous_buttons <= previous_buttons_next;
      start_held       <= start_held_next;
      hold_count       <= hold_count_next;
      song_choice      <= song_choice_next;
      note_position    <= note_position_next;
      duration_left    <= duration_left_next;
      gap_count        <= gap_count_next;
      tempo_halves     <= tempo_halves_next;
      status_bits      <= status_bits_next;
      led_red          <= led_red_next;
      led_green        <= led_green_next;
    end
  end

  // Tone of the note last loaded, or note zero before any
  assign tone_index = (note_position == '0) ? '0 : note_position - 1'b1;
  assign out_note   = msq_pkg::fetch_note(song_choice, tone_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tone_half_period <= out_note.tone;
      tone_enable      <= status_bits[msq_pkg::ST_SOUND];
      red_led          <= led_red;
      green_led        <= led_green;
      finished_flag    <= status_bits[msq_pkg::ST_FINISHED];
    end
  end

endmodule

>>> hdl/melody_sequencer_with_tempo_top.sv
// Top level of the melody sequencer with tempo control.
// Joins msq_ctrl and msq_datapath; uses msq_pkg.
//
// One input transfer is one timer tick carrying four active-low button
// levels; each tick yields exactly one result with the tone half-period,
// tone enable, the two LEDs and the finished flag. A tick passes through
// load, the ten-step restoring divider that turns a note length into a
// tick count at the current tempo, commit and emit. A new tick is taken
// only after the last tick's result is loaded, which waits while an
// earlier result is still stalled. The result waits in an output
// register while the next tick is taken. Configuration writes are taken
// at any time (cfg_ready is always high) but belong to idle periods.
module melody_sequencer_with_tempo_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // start_button, slower_button, faster_button,
                                 // select_button, 4'b0
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tone_half_period[13:0], tone_enable, red_led,
                                 // green_led, finished_flag, 6'b0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  msq_pkg::ctrl_cmd_t         cmd;
  msq_pkg::dp_status_t        status;
  logic [msq_pkg::TONE_W-1:0] tone_half_period;
  logic                       tone_enable;
  logic                       red_led;
  logic                       green_led;
  logic                       finished_flag;

  assign cfg_ready = 1'b1;

  msq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  msq_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .buttons          (s_tdata[3:0]),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .tone_half_period (tone_half_period),
    .tone_enable      (tone_enable),
    .red_led          (red_led),
    .green_led        (green_led),
    .finished_flag    (finished_flag)
  );

  assign m_tdata = {6'b0, finished_flag, green_led, red_led, tone_enable, tone_half_period};

endmodule

>>> hdl/msq_checker.sv
// Port-level checks for melody_sequencer_with_tempo_top, attached by bind.
// Depends only on the top level's ports.
module msq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one tick at a time: input closes after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // a finished song never sounds
  a_no_sound_when_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[14] && m_tdata[17]))
    else $error("tone enabled while finished");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind melody_sequencer_with_tempo_top msq_checker u_msq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
